[rtl/barcode_sample_slicer_top_assert.svh]
// Assertion macros for the barcode sample slicer.
`ifndef BARCODE_SAMPLE_SLICER_TOP_ASSERT_SVH
`define BARCODE_SAMPLE_SLICER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define BSS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("barcode slicer check failed");
`define BSS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("barcode slicer invariant failed");
`else
`define BSS_ASSERT(lbl, prop)
`define BSS_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[rtl/bss_pkg.sv]
// Types and constants shared by the barcode sample slicer.
package bss_pkg;

  localparam logic [1:0] CLS_ZERO  = 2'd0;
  localparam logic [1:0] CLS_ONE   = 2'd1;
  localparam logic [1:0] CLS_AMBIG = 2'd2;

  localparam logic [1:0] REG_LOW_THRESHOLD  = 2'd0;
  localparam logic [1:0] REG_HIGH_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_MIDPOINT       = 2'd2;

  localparam int OQ_DEPTH = 4;

  typedef struct packed {
    logic last_bit;
    logic was_ambiguous;
    logic bit_res;
  } res_t;

endpackage

[rtl/barcode_sample_slicer_top.sv]
// Barcode sample slicer: classifies reflectance samples and resolves ambiguous ones.
// The slicer takes one sample per cycle while ready. Each sample is classed against the
// low and high thresholds and held in a two-entry lookahead window, so a sample's result
// leaves two items later; an item with tlast set flushes the window and emits one to three
// results, the last with tlast set. Results go through a four-entry queue that drains one
// item per cycle while the output is ready; the input is ready while at most one result
// is queued, so a stream runs at that rate, and a flush of three holds the input while
// the queue drains. Configuration writes take effect at the next clock edge.
`include "barcode_sample_slicer_top_assert.svh"

module barcode_sample_slicer_top #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // Fields from bit 0: sample.
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // Fields from bit 0: bit_res, was_ambiguous.
  output logic [7:0]             m_axis_tdata,
  output logic                   m_axis_tlast,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [SAMPLE_BITS-1:0] cfg_data_i
);
  import bss_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam logic [SB-1:0] LowReset  = SB'((3299 * (2 ** SB)) / 10000);
  localparam logic [SB-1:0] HighReset = SB'((6539 * (2 ** SB)) / 10000);
  localparam logic [SB-1:0] MidReset  = SB'((2015 * (2 ** SB)) / 4096);

  logic [SB-1:0] low_q, high_q, mid_q;
  logic          prev_bit_q, prev_bit_d;
  logic          prev_valid_q, prev_valid_d;
  logic [SB-1:0] prev_sample_q, prev_sample_d;
  logic [SB-1:0] ahead_s_q [2];
  logic [SB-1:0] ahead_s_d [2];
  logic [1:0]    ahead_c_q [2];
  logic [1:0]    ahead_c_d [2];
  logic [1:0]    fill_q, fill_d;
  res_t          oq_q [OQ_DEPTH];
  res_t          oq_d [OQ_DEPTH];
  logic [2:0]    cnt_q, cnt_d;

  logic          acc, pop;
  logic [SB-1:0] s_new;
  logic [1:0]    c_new;
  logic [SB-1:0] ws [3];
  logic [1:0]    wc [3];
  logic [1:0]    n;
  logic          r0, r1, r2;
  res_t          e [3];
  logic [1:0]    npush;
  logic [2:0]    base;

  function automatic logic resolve(
    input logic          pv,
    input logic          pb,
    input logic [SB-1:0] ps,
    input logic [1:0]    c,
    input logic [SB-1:0] s,
    input logic [SB-1:0] mid,
    input logic          h1,
    input logic [1:0]    c1,
    input logic [SB-1:0] s1,
    input logic          h2,
    input logic [1:0]    c2,
    input logic [SB-1:0] s2
  );
    logic          bit_v;
    logic          use2;
    logic [1:0]    cj;
    logic [SB-1:0] sj;
    use2 = (c1 >= CLS_AMBIG) && h2;
    cj   = use2 ? c2 : c1;
    sj   = use2 ? s2 : s1;
    if (c < CLS_AMBIG) begin
      bit_v = c[0];
    end else if (!pv) begin
      bit_v = (s > mid);
    end else if (!h1) begin
      bit_v = ~pb;
    end else if (cj == {1'b0, pb}) begin
      bit_v = ~pb;
    end else begin
      bit_v = (ps < sj) ? pb : ~pb;
    end
    return bit_v;
  endfunction

  assign acc   = s_axis_tvalid && s_axis_tready;
  assign pop   = m_axis_tvalid && m_axis_tready;
  assign s_new = s_axis_tdata[SB-1:0];

  always_comb begin
    if (s_new < low_q) begin
      c_new = CLS_ZERO;
    end else if (s_new > high_q) begin
      c_new = CLS_ONE;
    end else begin
      c_new = CLS_AMBIG;
    end
  end

  always_comb begin
    ws[0] = '0; ws[1] = '0; ws[2] = '0;
    wc[0] = CLS_ZERO; wc[1] = CLS_ZERO; wc[2] = CLS_ZERO;
    case (fill_q)
      2'd0: begin
        ws[0] = s_new;        wc[0] = c_new;
      end
      2'd1: begin
        ws[0] = ahead_s_q[0]; wc[0] = ahead_c_q[0];
        ws[1] = s_new;        wc[1] = c_new;
      end
      default: begin
        ws[0] = ahead_s_q[0]; wc[0] = ahead_c_q[0];
        ws[1] = ahead_s_q[1]; wc[1] = ahead_c_q[1];
        ws[2] = s_new;        wc[2] = c_new;
      end
    endcase
    n = (fill_q >= 2'd2) ? 2'd3 : fill_q + 2'd1;
  end

  always_comb begin
    r0 = resolve(prev_valid_q, prev_bit_q, prev_sample_q, wc[0], ws[0], mid_q,
                 n > 2'd1, wc[1], ws[1], n > 2'd2, wc[2], ws[2]);
    r1 = resolve(1'b1, r0, ws[0], wc[1], ws[1], mid_q,
                 n > 2'd2, wc[2], ws[2], 1'b0, wc[2], ws[2]);
    r2 = resolve(1'b1, r1, ws[1], wc[2], ws[2], mid_q,
                 1'b0, wc[2], ws[2], 1'b0, wc[2], ws[2]);
  end

  always_comb begin
    prev_bit_d    = prev_bit_q;
    prev_valid_d  = prev_valid_q;
    prev_sample_d = prev_sample_q;
    ahead_s_d     = ahead_s_q;
    ahead_c_d     = ahead_c_q;
    fill_d        = fill_q;
    npush         = 2'd0;
    e[0] = '{last_bit: 1'b0, was_ambiguous: wc[0] >= CLS_AMBIG, bit_res: r0};
    e[1] = '{last_bit: 1'b0, was_ambiguous: wc[1] >= CLS_AMBIG, bit_res: r1};
    e[2] = '{last_bit: 1'b0, was_ambiguous: wc[2] >= CLS_AMBIG, bit_res: r2};
    if (acc) begin
      if (s_axis_tlast) begin
        npush = n;
        case (n)
          2'd1:    e[0].last_bit = 1'b1;
          2'd2:    e[1].last_bit = 1'b1;
          default: e[2].last_bit = 1'b1;
        endcase
        prev_valid_d = 1'b0;
        fill_d       = 2'd0;
      end else if (n == 2'd3) begin
        npush         = 2'd1;
        prev_bit_d    = r0;
        prev_sample_d = ws[0];
        prev_valid_d  = 1'b1;
        ahead_s_d[0]  = ws[1]; ahead_c_d[0] = wc[1];
        ahead_s_d[1]  = ws[2]; ahead_c_d[1] = wc[2];
        fill_d        = 2'd2;
      end else begin
        ahead_s_d[0]  = ws[0]; ahead_c_d[0] = wc[0];
        ahead_s_d[1]  = ws[1]; ahead_c_d[1] = wc[1];
        fill_d        = n;
      end
    end
  end

  always_comb begin
    int k;
    base  = cnt_q - {2'b00, pop};
    cnt_d = base + {1'b0, npush};
    for (int p = 0; p < OQ_DEPTH; p++) begin
      k = p - int'(base);
      if (p < int'(base)) begin
        oq_d[p] = pop ? oq_q[(p + 1) % OQ_DEPTH] : oq_q[p];
      end else if (k < int'(npush)) begin
        oq_d[p] = e[2'(k)];
      end else begin
        oq_d[p] = oq_q[p];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q         <= LowReset;
      high_q        <= HighReset;
      mid_q         <= MidReset;
      prev_bit_q    <= 1'b0;
      prev_valid_q  <= 1'b0;
      prev_sample_q <= '0;
      ahead_s_q[0]  <= '0;
      ahead_s_q[1]  <= '0;
      ahead_c_q[0]  <= CLS_ZERO;
      ahead_c_q[1]  <= CLS_ZERO;
      fill_q        <= 2'd0;
      cnt_q         <= 3'd0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_LOW_THRESHOLD:  low_q  <= cfg_data_i;
          REG_HIGH_THRESHOLD: high_q <= cfg_data_i;
          REG_MIDPOINT:       mid_q  <= cfg_data_i;
          default: ;
        endcase
      end
      prev_bit_q    <= prev_bit_d;
      prev_valid_q  <= prev_valid_d;
      prev_sample_q <= prev_sample_d;
      ahead_s_q     <= ahead_s_d;
      ahead_c_q     <= ahead_c_d;
      fill_q        <= fill_d;
      cnt_q         <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oq_q <= oq_d;
  end

  assign s_axis_tready = (cnt_q <= 3'd1);
  assign m_axis_tvalid = (cnt_q != 3'd0);
  assign m_axis_tdata  = {6'b000000, oq_q[0].was_ambiguous, oq_q[0].bit_res};
  assign m_axis_tlast  = oq_q[0].last_bit;

  `BSS_ASSERT_ALWAYS(a_cnt_bound, !rst_ni || (cnt_q <= 3'(OQ_DEPTH) && fill_q <= 2'd2))
  `BSS_ASSERT(a_flush_clears, acc && s_axis_tlast |=> fill_q == 2'd0 && !prev_valid_q)
  `BSS_ASSERT(a_flush_three, acc && s_axis_tlast && fill_q == 2'd2 && !pop |=>
              cnt_q == $past(cnt_q) + 3'd3)
  `BSS_ASSERT(a_tail_one, acc && !s_axis_tlast && fill_q == 2'd2 && pop |=>
              cnt_q == $past(cnt_q))

endmodule
